// ===== src/kmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Key matrix scan debounce package
// Shared widths, constants, register indexes and struct types of the
// key matrix scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmsd_pkg;

   // Fixed field widths.
   localparam int ROW_W      = 8;
   localparam int COLUMN_W   = 4;
   localparam int DRIVE_W    = 9;
   localparam int COUNT_W    = 8;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_INDEX_W = 2;

   // Parameter defaults for the top level.
   localparam int DEF_NUM_COLUMNS = 9;
   localparam int DEF_NUM_ROWS    = 8;

   // Match count saturation point.
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 8'hF0;

   // Reset values.
   localparam logic [ROW_W-1:0]    ROWS_RELEASED     = 8'hFF;
   localparam logic [COUNT_W-1:0]  KEY_CONFIRM_RST   = 8'd1;
   localparam logic [COUNT_W-1:0]  PANEL_CONFIRM_RST = 8'd7;
   localparam logic [COLUMN_W-1:0] PANEL_FIRST_RST   = 4'd7;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_CONFIRM   = 2'd0,
      CSR_PANEL_CONFIRM = 2'd1,
      CSR_PANEL_FIRST   = 2'd2
   } csr_index_type;

   // Configuration values seen by the datapath.
   typedef struct packed {
      logic [COUNT_W-1:0]  key_confirm_count;
      logic [COUNT_W-1:0]  panel_confirm_count;
      logic [COLUMN_W-1:0] panel_first_column;
   } cfg_type;

   // One sample in the input register.
   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    rows;
   } item_type;

   // One result as loaded into the output register.
   typedef struct packed {
      logic [COLUMN_W-1:0] scanned_column;
      logic [ROW_W-1:0]    debounced_rows;
      logic                committed;
      logic [DRIVE_W-1:0]  next_column_drive;
      logic                end_of_scan;
   } result_type;

endpackage

// ===== src/kmsd_if.sv =====
// ----------------------------------------------------------------------------
// Key matrix scan debounce channel interfaces
// Valid/ready channels for row samples and for scan results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kmsd_req_if;
   logic                       valid;
   logic                       ready;
   logic [kmsd_pkg::ROW_W-1:0] row_sample;

   modport source (output valid, output row_sample, input ready);
   modport sink   (input valid, input row_sample, output ready);
endinterface

interface kmsd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kmsd_pkg::COLUMN_W-1:0] scanned_column;
   logic [kmsd_pkg::ROW_W-1:0]    debounced_rows;
   logic                          committed;
   logic [kmsd_pkg::DRIVE_W-1:0]  next_column_drive;
   logic                          end_of_scan;

   modport source (
      output valid, output scanned_column, output debounced_rows,
      output committed, output next_column_drive, output end_of_scan,
      input ready
   );
   modport sink (
      input valid, input scanned_column, input debounced_rows,
      input committed, input next_column_drive, input end_of_scan,
      output ready
   );
endinterface

// ===== src/key_matrix_scan_debounce.sv =====
// ----------------------------------------------------------------------------
// Key matrix scan debounce
// Scans a key matrix one column per row sample and debounces each column.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on req_chan carries the row byte sampled for the column
// currently selected; columns are visited 0 to NUM_COLUMNS-1 and then wrap.
// Each accepted sample yields exactly one transaction on rsp_chan with the
// column index, its debounced row byte, a commit flag, the active-low drive
// for the next column and an end-of-pass flag.
// A sample enters an input register, is debounced against its column entry
// and lands in the output register; while the output register holds an
// untaken result, the sample waits in the input register.
// One sample per cycle is sustained while rsp_chan.ready stays high; the rate
// is set by the read-modify-write of the column entry.
// Reset clears both registers, sets every column to released (0xFF) with a
// zero match count, restarts the scan at column 0 and loads the default
// thresholds. When rsp_chan.ready is low the output register holds its
// transaction and the input register still takes one more sample before
// req_chan.ready drops. Configuration is written through the csr_ port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_matrix_scan_debounce #(
   parameter int NUM_COLUMNS = kmsd_pkg::DEF_NUM_COLUMNS,
   parameter int NUM_ROWS    = kmsd_pkg::DEF_NUM_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   kmsd_req_if.sink                         req_chan,
   kmsd_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [kmsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kmsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import kmsd_pkg::*;

   localparam logic [ROW_W-1:0]    UNUSED_ROWS = ROW_W'(8'hFF << NUM_ROWS);
   localparam logic [COLUMN_W-1:0] LAST_COLUMN = COLUMN_W'(NUM_COLUMNS - 1);

   cfg_type             cfg;
   item_type            item_ff;
   item_type            item_in;
   logic                item_valid_ff;
   logic                item_valid_in;
   result_type          result;
   result_type          result_ff;
   result_type          result_in;
   logic                result_valid_ff;
   logic                result_valid_in;
   logic [COLUMN_W-1:0] column_ptr_ff;
   logic [COLUMN_W-1:0] column_ptr_in;
   logic                req_take;
   logic                advance;

   kmsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kmsd_column_state #(
      .NUM_COLUMNS (NUM_COLUMNS)
   ) u_column_state (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .update (advance),
      .item   (item_ff),
      .result (result)
   );

   // Handshake and pipeline movement.
   assign advance        = item_valid_ff && (!result_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Input register: tag the sample with its column and force unused rows high.
   always_comb begin
      item_in        = item_ff;
      item_valid_in  = item_valid_ff && !advance;
      column_ptr_in  = column_ptr_ff;
      if (req_take) begin
         item_in.column = column_ptr_ff;
         item_in.rows   = req_chan.row_sample | UNUSED_ROWS;
         item_valid_in  = 1'b1;
         column_ptr_in  = (column_ptr_ff == LAST_COLUMN) ? '0 : column_ptr_ff + 1'b1;
      end
   end

   // Output register holds a result until the receiver takes it.
   always_comb begin
      result_in       = result_ff;
      result_valid_in = result_valid_ff && !rsp_chan.ready;
      if (advance) begin
         result_in       = result;
         result_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
         column_ptr_ff   <= '0;
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
         column_ptr_ff   <= column_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_chan.valid             = result_valid_ff;
   assign rsp_chan.scanned_column    = result_ff.scanned_column;
   assign rsp_chan.debounced_rows    = result_ff.debounced_rows;
   assign rsp_chan.committed         = result_ff.committed;
   assign rsp_chan.next_column_drive = result_ff.next_column_drive;
   assign rsp_chan.end_of_scan       = result_ff.end_of_scan;

`ifndef SYNTH
   // The pipeline is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid && req_chan.ready)
      else $error("result pending right after reset");

   // Input back-pressure only when both registers are full and stalled.
   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> item_valid_ff && result_valid_ff && !rsp_chan.ready)
      else $error("input stalled while the pipeline could move");

   // A committed byte has every unused row released.
   a_commit_unused_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.committed |->
         ((rsp_chan.debounced_rows & UNUSED_ROWS) == UNUSED_ROWS))
      else $error("committed byte drives an unused row");

   // At most one column is driven at a time.
   a_drive_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $countones(~rsp_chan.next_column_drive) <= 1)
      else $error("more than one column driven");
`endif

endmodule

// ===== src/kmsd_csr.sv =====
// ----------------------------------------------------------------------------
// Key matrix scan debounce configuration registers
// Holds the two confirm thresholds and the first panel column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmsd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [kmsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kmsd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output kmsd_pkg::cfg_type                   cfg
);
   import kmsd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index; writes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_CONFIRM:   cfg_in.key_confirm_count   = csr_wdata;
            CSR_PANEL_CONFIRM: cfg_in.panel_confirm_count = csr_wdata;
            CSR_PANEL_FIRST:   cfg_in.panel_first_column  = csr_wdata[COLUMN_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_confirm_count   <= KEY_CONFIRM_RST;
         cfg_ff.panel_confirm_count <= PANEL_CONFIRM_RST;
         cfg_ff.panel_first_column  <= PANEL_FIRST_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/kmsd_column_state.sv =====
// ----------------------------------------------------------------------------
// Key matrix scan debounce column state
// Per-column pending byte, match count and debounced byte, with the
// debounce update and result formation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmsd_column_state #(
   parameter int NUM_COLUMNS = kmsd_pkg::DEF_NUM_COLUMNS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kmsd_pkg::cfg_type      cfg,
   input  logic                   update,
   input  kmsd_pkg::item_type     item,
   output kmsd_pkg::result_type   result
);
   import kmsd_pkg::*;

   localparam int IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam logic [COLUMN_W-1:0] LAST_COLUMN = COLUMN_W'(NUM_COLUMNS - 1);

   logic [ROW_W-1:0]   debounced_ff [NUM_COLUMNS];
   logic [ROW_W-1:0]   pending_ff   [NUM_COLUMNS];
   logic [COUNT_W-1:0] count_ff     [NUM_COLUMNS];

   logic [IDX_W-1:0]    idx;
   logic [ROW_W-1:0]    pending_rd;
   logic [COUNT_W-1:0]  count_rd;
   logic [ROW_W-1:0]    debounced_rd;
   logic [COUNT_W-1:0]  threshold;
   logic                match;
   logic                commit;
   logic [COUNT_W-1:0]  count_new;
   logic [COLUMN_W-1:0] next_column;

   assign idx          = item.column[IDX_W-1:0];
   assign pending_rd   = pending_ff[idx];
   assign count_rd     = count_ff[idx];
   assign debounced_rd = debounced_ff[idx];

   // Panel columns use their own threshold.
   assign threshold = (item.column >= cfg.panel_first_column) ? cfg.panel_confirm_count
                                                              : cfg.key_confirm_count;

   // A matching sample raises the saturating count; the prior count decides a commit.
   assign match     = (item.rows == pending_rd);
   assign commit    = match && (count_rd == threshold);
   assign count_new = !match ? '0 :
                      (count_rd < COUNT_LIMIT) ? count_rd + 1'b1 : count_rd;

   // Column state is written when the sample moves to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COLUMNS; i++) begin
            debounced_ff[i] <= ROWS_RELEASED;
            pending_ff[i]   <= ROWS_RELEASED;
            count_ff[i]     <= '0;
         end
      end else if (update) begin
         pending_ff[idx] <= item.rows;
         count_ff[idx]   <= count_new;
         if (commit) begin
            debounced_ff[idx] <= item.rows;
         end
      end
   end

   // Next column wraps to zero after the last one.
   assign next_column = (item.column == LAST_COLUMN) ? '0 : item.column + 1'b1;

   always_comb begin
      result.scanned_column = item.column;
      result.debounced_rows = commit ? item.rows : debounced_rd;
      result.committed      = commit;
      result.end_of_scan    = (item.column == LAST_COLUMN);
      if (next_column < COLUMN_W'(DRIVE_W)) begin
         result.next_column_drive = ~(DRIVE_W'(1) << next_column);
      end else begin
         result.next_column_drive = '1;
      end
   end

endmodule

// ===== sim/key_matrix_scan_debounce_test.sv =====
// ----------------------------------------------------------------------------
// Key matrix scan debounce testbench
// Drives row samples through the scanner with random idling on both
// channels, predicts every result transaction from a model of the column
// debounce state kept here, and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_matrix_scan_debounce_test;
   import kmsd_pkg::*;

   localparam int NUM_COLUMNS = DEF_NUM_COLUMNS;
   localparam int NUM_ROWS    = DEF_NUM_ROWS;
   localparam int PHASE_ITEMS = 95;
   localparam int RANDOM_PHASES = 8;
   // Several passes of settled samples over every column.
   localparam int SATURATE_ITEMS = 20 * NUM_COLUMNS;
   localparam longint TIMEOUT_NS = 64'd10_000_000;
   localparam int MAX_REPORTS = 10;

   // Row bits above NUM_ROWS read as released.
   localparam logic [ROW_W-1:0] UNUSED_ROWS = ROW_W'(16'hFF << NUM_ROWS);

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   kmsd_req_if req_chan ();
   kmsd_rsp_if rsp_chan ();

   key_matrix_scan_debounce #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .NUM_ROWS    (NUM_ROWS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Debounce state mirrored from the block, plus its thresholds.
   logic [ROW_W-1:0]    debounced_rows [NUM_COLUMNS];
   logic [ROW_W-1:0]    pending_rows [NUM_COLUMNS];
   logic [COUNT_W-1:0]  match_cnt [NUM_COLUMNS];
   int                  scan_col;
   logic [COUNT_W-1:0]  key_confirm;
   logic [COUNT_W-1:0]  panel_confirm;
   logic [COLUMN_W-1:0] panel_first;

   // Samples waiting to be sent and scan reports waiting to arrive.
   logic [ROW_W-1:0] row_samples_pending [$];
   result_type       scan_reports_due [$];

   // Stimulus-side view of the matrix: the byte each column is settling to.
   logic [ROW_W-1:0] held_rows [NUM_COLUMNS];
   int               next_stim_col;

   bit send_idle_on;
   bit recv_idle_on;
   int send_gap;
   int recv_stall;
   int fail_count;
   result_type arrived_due;

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Counts a failure and reports the first few of them.
   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t ns: %s", $time, msg);
      end
   endfunction

   function automatic void compare_field(input string field, input int column,
                                         input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         note_failure($sformatf("column %0d %s: expected %0h, got %0h",
                                column, field, want, got));
      end
   endfunction

   // Applies one accepted sample to the debounce state and queues the report.
   task automatic debounce_sample(input logic [ROW_W-1:0] sample);
      int                 col;
      int                 nxt;
      logic [ROW_W-1:0]   rows;
      logic [COUNT_W-1:0] threshold;
      logic [COUNT_W-1:0] prior;
      result_type         report;
      col = scan_col;
      if (col >= NUM_COLUMNS) begin
         col = 0;
      end
      rows = sample | UNUSED_ROWS;
      threshold = (col >= panel_first) ? panel_confirm : key_confirm;
      report.committed = 1'b0;
      if (rows == pending_rows[col]) begin
         prior = match_cnt[col];
         if (prior < COUNT_LIMIT) begin
            match_cnt[col] = prior + 1'b1;
         end
         // A met threshold commits even when the byte is unchanged.
         if (prior == threshold) begin
            debounced_rows[col] = rows;
            report.committed = 1'b1;
         end
      end else begin
         pending_rows[col] = rows;
         match_cnt[col] = '0;
      end
      nxt = col + 1;
      if (nxt >= NUM_COLUMNS) begin
         nxt = 0;
      end
      // Columns past the drive width leave every select line released.
      if (nxt < DRIVE_W) begin
         report.next_column_drive = ~(DRIVE_W'(1) << nxt);
      end else begin
         report.next_column_drive = '1;
      end
      scan_col = nxt;
      report.scanned_column = COLUMN_W'(col);
      report.debounced_rows = debounced_rows[col];
      report.end_of_scan = (col == NUM_COLUMNS - 1);
      scan_reports_due.push_back(report);
   endtask

   // Sender: presents queued samples, with idle bursts when enabled.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            debounce_sample(req_chan.row_sample);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (send_idle_on && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 15);
               req_chan.valid <= 1'b0;
            end else if (row_samples_pending.size() != 0) begin
               req_chan.valid <= 1'b1;
               req_chan.row_sample <= row_samples_pending.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure in random bursts when enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall = 0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_chan.ready <= 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
         recv_stall = $urandom_range(0, 15);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Monitor: each result transaction is checked against the oldest report.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (scan_reports_due.size() == 0) begin
            note_failure("result transaction arrived with none outstanding");
         end else begin
            arrived_due = scan_reports_due.pop_front();
            compare_field("scanned_column", int'(arrived_due.scanned_column),
                          16'(arrived_due.scanned_column),
                          16'(rsp_chan.scanned_column));
            compare_field("debounced_rows", int'(arrived_due.scanned_column),
                          16'(arrived_due.debounced_rows),
                          16'(rsp_chan.debounced_rows));
            compare_field("committed", int'(arrived_due.scanned_column),
                          16'(arrived_due.committed), 16'(rsp_chan.committed));
            compare_field("next_column_drive", int'(arrived_due.scanned_column),
                          16'(arrived_due.next_column_drive),
                          16'(rsp_chan.next_column_drive));
            compare_field("end_of_scan", int'(arrived_due.scanned_column),
                          16'(arrived_due.end_of_scan),
                          16'(rsp_chan.end_of_scan));
         end
      end
   end

   // Register write while the block is idle; the local copy follows it.
   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_KEY_CONFIRM:   key_confirm = value;
         CSR_PANEL_CONFIRM: panel_confirm = value;
         CSR_PANEL_FIRST:   panel_first = value[COLUMN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every queued sample has produced its result.
   task automatic wait_until_drained();
      do
         @(posedge clock);
      while (row_samples_pending.size() != 0 || req_chan.valid ||
             scan_reports_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_sample(input logic [ROW_W-1:0] sample);
      row_samples_pending.push_back(sample);
      next_stim_col = (next_stim_col + 1) % NUM_COLUMNS;
   endtask

   // Mostly settled columns, with occasional key changes and contact bounce.
   task automatic queue_scan_phase(input int count, input int change_pct,
                                   input int bounce_pct);
      logic [ROW_W-1:0] sample;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < change_pct) begin
            if ($urandom_range(0, 3) == 0) begin
               held_rows[next_stim_col] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end else begin
               held_rows[next_stim_col] = ROW_W'($urandom);
            end
         end
         if ($urandom_range(0, 99) < bounce_pct) begin
            sample = ROW_W'($urandom);
         end else begin
            sample = held_rows[next_stim_col];
         end
         push_sample(sample);
      end
   endtask

   // Small thresholds most of the time so that commits are frequent.
   function automatic logic [COUNT_W-1:0] pick_threshold();
      case ($urandom_range(0, 9))
         6:       return '0;
         7:       return COUNT_W'($urandom_range(0, 239));
         8:       return 8'd239;
         9:       return $urandom_range(0, 1) ? 8'hFF : COUNT_W'($urandom_range(240, 255));
         default: return COUNT_W'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [COLUMN_W-1:0] pick_panel_first();
      case ($urandom_range(0, 6))
         0:       return 4'd0;
         1:       return 4'd1;
         2:       return 4'd7;
         3:       return 4'd8;
         4:       return 4'd9;
         5:       return 4'd15;
         default: return COLUMN_W'($urandom_range(0, 15));
      endcase
   endfunction

   // Stimulus sequence and end of run.
   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      fail_count = 0;
      next_stim_col = 0;
      scan_col = 0;
      key_confirm = KEY_CONFIRM_RST;
      panel_confirm = PANEL_CONFIRM_RST;
      panel_first = PANEL_FIRST_RST;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         debounced_rows[c] = ROWS_RELEASED;
         pending_rows[c] = ROWS_RELEASED;
         match_cnt[c] = '0;
         held_rows[c] = ROWS_RELEASED;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: threshold zero commits on the first match, including a
      // released byte that commits unchanged. The panel threshold is above
      // the saturation point and the panel start lies beyond the columns.
      write_register(CSR_KEY_CONFIRM, 8'd0);
      write_register(CSR_PANEL_CONFIRM, 8'hFF);
      write_register(CSR_PANEL_FIRST, 8'd15);
      for (int pass = 0; pass < 2; pass++) begin
         push_sample(8'hFF);
         push_sample(8'h00);
         push_sample(8'h80);
         push_sample(8'h01);
         push_sample(8'h7F);
         push_sample(8'hFE);
         push_sample(8'h55);
         push_sample(8'hAA);
         push_sample(8'hFF);
      end
      wait_until_drained();

      // Random phases, each with a fresh configuration and idling mix.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_register(CSR_KEY_CONFIRM, pick_threshold());
         write_register(CSR_PANEL_CONFIRM, pick_threshold());
         write_register(CSR_PANEL_FIRST, CSR_DATA_W'(pick_panel_first()));
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         queue_scan_phase(PHASE_ITEMS, 10, $urandom_range(0, 20));
         wait_until_drained();
      end

      // Long settled stretch: key columns never commit with a threshold
      // above saturation, and panel columns set to the saturation point
      // stay uncommitted while their counts are still below it.
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      write_register(CSR_KEY_CONFIRM, 8'hFF);
      write_register(CSR_PANEL_CONFIRM, COUNT_LIMIT);
      write_register(CSR_PANEL_FIRST, 8'd4);
      queue_scan_phase(SATURATE_ITEMS, 0, 0);
      wait_until_drained();

      // Closing phase at full rate on both channels.
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      write_register(CSR_KEY_CONFIRM, 8'd239);
      write_register(CSR_PANEL_CONFIRM, 8'd1);
      write_register(CSR_PANEL_FIRST, 8'd8);
      queue_scan_phase(PHASE_ITEMS, 10, 10);
      wait_until_drained();

      repeat (16) @(posedge clock);
      if (fail_count == 0 && scan_reports_due.size() == 0) begin
         $display("key_matrix_scan_debounce_test passed");
      end else begin
         $display("key_matrix_scan_debounce_test failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #TIMEOUT_NS;
      $display("key_matrix_scan_debounce_test failed");
      $finish;
   end

endmodule

// ===== key_matrix_scan_debounce.f =====
src/kmsd_pkg.sv
src/kmsd_if.sv
src/kmsd_csr.sv
src/kmsd_column_state.sv
src/key_matrix_scan_debounce.sv
sim/key_matrix_scan_debounce_test.sv
